[hdl/acs_pkg.sv]
package acs_pkg;

  // default widths of the sample path
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // fixed field widths
  localparam int LEVEL_W    = 24;
  localparam int COEF_W     = 16;
  localparam int REFR_W     = 16;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // serial multiply-accumulate: 17 multiplier bits (coefficient up to 65536)
  localparam int MAC_BITS = COEF_W + 1;
  localparam int PROD_W   = LEVEL_W + MAC_BITS;
  localparam int RND_POS  = 16;

  localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(32768);
  localparam logic [MAC_BITS-1:0] COEF_ONE   = MAC_BITS'(65536);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HP_ALPHA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_DECAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY      = 3'd6;

  // register reset values
  localparam logic [COEF_W-1:0]  RST_HP_ALPHA   = 16'd58982;
  localparam logic [COEF_W-1:0]  RST_THR_DECAY  = 16'd655;
  localparam logic [LEVEL_W-1:0] RST_MIN_THR    = 24'd629146;
  localparam logic [LEVEL_W-1:0] RST_MAX_THR    = 24'd5242880;
  localparam logic [REFR_W-1:0]  RST_REFRACTORY = 16'd180;
  localparam logic [LEVEL_W-1:0] RST_INIT_THR   = 24'd1258291;
  localparam logic [LEVEL_W-1:0] RST_GRAVITY    = 24'd2097152;

  // status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[hdl/accel_step_detector.sv]
// One word in flight: the next word is taken in the idle state, after the result of the
//   previous word is registered at the output.
// The serial squarer, the bit-per-cycle square root and two passes of the shared
//   shift-add multiplier process each word in turn; a result may wait at the output
//   while the next word is taken.
// Reset (rst_n low, synchronous) loads the register defaults and the filter start values.
module accel_step_detector #(
  parameter int SAMPLE_BITS = acs_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = acs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_z,
  input  logic [acs_pkg::TIME_W-1:0]           in_time_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_step_detected,
  output logic [acs_pkg::COUNT_W-1:0]          out_total_steps,
  output logic [acs_pkg::LEVEL_W-1:0]          out_rectified_level,
  output logic [acs_pkg::LEVEL_W-1:0]          out_threshold_level,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [acs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SB   = SAMPLE_BITS;
  localparam int QW   = SAMPLE_BITS + FRAC_BITS;
  localparam int LW   = acs_pkg::LEVEL_W;
  localparam int CWF  = acs_pkg::COEF_W;
  localparam int MB   = acs_pkg::MAC_BITS;
  localparam int PW   = acs_pkg::PROD_W;
  localparam int EXTW = (QW > LW) ? QW : LW + 1;
  localparam int THW  = LW + 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_LP   = 3'd3;
  localparam logic [2:0] ST_DIFF = 3'd4;
  localparam logic [2:0] ST_TH   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [CWF-1:0]                alpha_r, decay_r;
  logic [LW-1:0]                 min_r, max_r;
  logic [acs_pkg::REFR_W-1:0]    refr_r;

  // filter state
  logic [LW-1:0]                 lp_r, th_r, prev_r, level_r, mag_r;
  logic [acs_pkg::TIME_W-1:0]    last_r, time_r;
  logic [acs_pkg::COUNT_W-1:0]   cnt_r;
  logic                          ge_r;

  // output register
  logic                          out_valid_r, out_step_r;
  logic [acs_pkg::COUNT_W-1:0]   out_total_r;
  logic [LW-1:0]                 out_level_r, out_th_r;

  // unit connections
  acs_pkg::unit_stat_t           sq_stat, rt_stat, mac_stat;
  logic [2*SB-1:0]               sum;
  logic [QW-1:0]                 root;
  logic                          sq_start, mac_start;
  logic [LW-1:0]                 mac_a1, mac_a2;
  logic [MB-1:0]                 mac_b1, mac_b2;
  logic [PW-1:0]                 mac_acc, mac_rnd;

  // datapath helpers
  logic [EXTW-1:0]               root_ext;
  logic [LW-1:0]                 mag_sat, lp_new, level_c, diff_c, th_new;
  logic                          ge_c;
  logic [LW:0]                   delta;
  logic signed [THW-1:0]         th_sum, th_lo;
  logic [acs_pkg::TIME_W-1:0]    elapsed;
  logic                          rising, step, commit, cfg_wr;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign sq_start  = in_valid && in_ready;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  acs_sqsum #(.SB(SB)) u_sqsum (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (in_accel_x),
    .y     (in_accel_y),
    .z     (in_accel_z),
    .sum   (sum),
    .stat  (sq_stat)
  );

  acs_isqrt #(.SB(SB), .FB(FRAC_BITS)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_stat.done),
    .sum   (sum),
    .root  (root),
    .stat  (rt_stat)
  );

  acs_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a1    (mac_a1),
    .b1    (mac_b1),
    .a2    (mac_a2),
    .b2    (mac_b2),
    .acc   (mac_acc),
    .stat  (mac_stat)
  );

  // saturate the magnitude to the level width
  assign root_ext = EXTW'(root);
  assign mag_sat  = (root_ext > EXTW'(acs_pkg::LEVEL_MAX)) ? acs_pkg::LEVEL_MAX
                                                            : LW'(root);

  // rounded product, shared by both passes
  assign mac_rnd = mac_acc + acs_pkg::ROUND_HALF;
  assign lp_new  = mac_rnd[acs_pkg::RND_POS +: LW];
  assign delta   = mac_rnd[acs_pkg::RND_POS +: LW+1];
  assign level_c = (mag_r >= lp_new) ? (mag_r - lp_new) : (lp_new - mag_r);

  // distance of the level from the threshold
  assign ge_c   = (level_r >= th_r);
  assign diff_c = ge_c ? (level_r - th_r) : (th_r - level_r);

  // select multiplier operands: low-pass pass, then threshold pass
  always_comb begin
    if (state_r == ST_DIFF) begin
      mac_start = 1'b1;
      mac_a1    = diff_c;
      mac_b1    = MB'(decay_r);
      mac_a2    = '0;
      mac_b2    = '0;
    end else begin
      mac_start = (state_r == ST_SQRT) && rt_stat.done;
      mac_a1    = lp_r;
      mac_b1    = MB'(alpha_r);
      mac_a2    = mag_sat;
      mac_b2    = acs_pkg::COEF_ONE - MB'(alpha_r);
    end
  end

  // move the threshold and clamp it, upper bound last
  always_comb begin
    th_sum = ge_r ? (THW'(th_r) + THW'(delta)) : (THW'(th_r) - THW'(delta));
    th_lo  = (th_sum < $signed(THW'(min_r))) ? $signed(THW'(min_r)) : th_sum;
    th_new = (th_lo > $signed(THW'(max_r))) ? max_r : LW'(th_lo);
  end

  // step decision
  assign rising  = (level_r > prev_r);
  assign elapsed = time_r - last_r;
  assign step    = (level_r > th_new) && !rising
                && (elapsed > acs_pkg::TIME_W'(refr_r));

  // sequence one word through the units
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (sq_start) state_nxt = ST_SQ;
      ST_SQ:   if (sq_stat.done) state_nxt = ST_SQRT;
      ST_SQRT: if (rt_stat.done) state_nxt = ST_LP;
      ST_LP:   if (mac_stat.done) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_TH;
      ST_TH:   if (mac_stat.done) state_nxt = ST_FIN;
      ST_FIN:  if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers; start values go straight into the filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= acs_pkg::RST_HP_ALPHA;
      decay_r <= acs_pkg::RST_THR_DECAY;
      min_r   <= acs_pkg::RST_MIN_THR;
      max_r   <= acs_pkg::RST_MAX_THR;
      refr_r  <= acs_pkg::RST_REFRACTORY;
    end else if (cfg_wr) begin
      case (cfg_index)
        acs_pkg::REG_HP_ALPHA:   alpha_r <= CWF'(cfg_data);
        acs_pkg::REG_THR_DECAY:  decay_r <= CWF'(cfg_data);
        acs_pkg::REG_MIN_THR:    min_r   <= cfg_data;
        acs_pkg::REG_MAX_THR:    max_r   <= cfg_data;
        acs_pkg::REG_REFRACTORY: refr_r  <= acs_pkg::REFR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // filter state; start-value writes load the state at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r   <= acs_pkg::RST_GRAVITY;
      th_r   <= acs_pkg::RST_INIT_THR;
      prev_r <= '0;
      last_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cfg_wr && cfg_index == acs_pkg::REG_GRAVITY) begin
        lp_r <= cfg_data;
      end else if (state_r == ST_LP && mac_stat.done) begin
        lp_r <= lp_new;
      end
      if (cfg_wr && cfg_index == acs_pkg::REG_INIT_THR) begin
        th_r <= cfg_data;
      end else if (commit) begin
        th_r <= th_new;
      end
      if (commit) begin
        prev_r <= level_r;
        if (step) begin
          cnt_r  <= cnt_r + 1'b1;
          last_r <= time_r;
        end
      end
    end
  end

  // hold per-word values
  always_ff @(posedge clk) begin
    if (sq_start) begin
      time_r <= in_time_ms;
    end
    if (state_r == ST_SQRT && rt_stat.done) begin
      mag_r <= mag_sat;
    end
    if (state_r == ST_LP && mac_stat.done) begin
      level_r <= level_c;
    end
    if (state_r == ST_DIFF) begin
      ge_r <= ge_c;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_step_r  <= step;
      out_total_r <= step ? (cnt_r + 1'b1) : cnt_r;
      out_level_r <= level_r;
      out_th_r    <= th_new;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_detected   = out_step_r;
  assign out_total_steps     = out_total_r;
  assign out_rectified_level = out_level_r;
  assign out_threshold_level = out_th_r;

  // the serial units never overlap
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({sq_stat.busy, rt_stat.busy, mac_stat.busy}) <= 1)
    else $error("serial units overlap");

  // nothing is in flight while a new word may enter
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sq_stat.busy && !rt_stat.busy && !mac_stat.busy)
    else $error("unit busy while input ready");

  // the square root follows the squarer directly
  a_sqrt_follows: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |=> rt_stat.busy)
    else $error("square root did not start");

  // a counted step advances the counter by one
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && step) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("step counter did not advance");

endmodule

[hdl/acs_sqsum.sv]
module acs_sqsum #(
  parameter int SB = acs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [SB-1:0] x,
  input  logic signed [SB-1:0] y,
  input  logic signed [SB-1:0] z,
  output logic [2*SB-1:0]      sum,
  output acs_pkg::unit_stat_t  stat
);

  localparam int SW = 2 * SB;
  localparam int CW = $clog2(SB + 1);

  logic [SB-1:0] bx_r, by_r, bz_r;
  logic [SW-1:0] mx_r, my_r, mz_r;
  logic [SW-1:0] acc_r, acc_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [SB-1:0] ax, ay, az;

  // magnitudes of the axes (most negative value maps onto its own pattern)
  assign ax = x[SB-1] ? (~x + 1'b1) : x;
  assign ay = y[SB-1] ? (~y + 1'b1) : y;
  assign az = z[SB-1] ? (~z + 1'b1) : z;

  // add one partial product of each axis per cycle
  always_comb begin
    acc_nxt = acc_r + (bx_r[0] ? mx_r : '0) + (by_r[0] ? my_r : '0)
            + (bz_r[0] ? mz_r : '0);
  end

  // shift multipliers down and multiplicands up
  always_ff @(posedge clk) begin
    if (start) begin
      bx_r  <= ax;
      by_r  <= ay;
      bz_r  <= az;
      mx_r  <= SW'(ax);
      my_r  <= SW'(ay);
      mz_r  <= SW'(az);
      acc_r <= '0;
    end else if (busy_r) begin
      bx_r  <= bx_r >> 1;
      by_r  <= by_r >> 1;
      bz_r  <= bz_r >> 1;
      mx_r  <= mx_r << 1;
      my_r  <= my_r << 1;
      mz_r  <= mz_r << 1;
      acc_r <= acc_nxt;
    end
  end

  // sequence the multiplier bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(SB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign sum       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/acs_isqrt.sv]
module acs_isqrt #(
  parameter int SB = acs_pkg::SAMPLE_BITS_DEF,
  parameter int FB = acs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2*SB-1:0]     sum,
  output logic [SB+FB-1:0]    root,
  output acs_pkg::unit_stat_t stat
);

  localparam int RW  = 2 * (SB + FB);
  localparam int QW  = SB + FB;
  localparam int RMW = QW + 2;
  localparam int CW  = $clog2(QW + 1);

  logic [RW-1:0]    n_r;
  logic [QW-1:0]    root_r, root_nxt;
  logic [RMW-1:0]   rem_r, rem_nxt;
  logic [RMW+1:0]   rem_sh, trial;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;

  // one root bit per cycle: bring down two radicand bits and try a subtract
  always_comb begin
    rem_sh = {rem_r, n_r[RW-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = RMW'(rem_sh - trial);
      root_nxt = {root_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = RMW'(rem_sh);
      root_nxt = {root_r[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= {sum, {(2*FB){1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= n_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  // count root digits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/acs_mac.sv]
module acs_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [acs_pkg::LEVEL_W-1:0]           a1,
  input  logic [acs_pkg::MAC_BITS-1:0]          b1,
  input  logic [acs_pkg::LEVEL_W-1:0]           a2,
  input  logic [acs_pkg::MAC_BITS-1:0]          b2,
  output logic [acs_pkg::PROD_W-1:0]            acc,
  output acs_pkg::unit_stat_t                   stat
);

  localparam int PW = acs_pkg::PROD_W;
  localparam int MB = acs_pkg::MAC_BITS;
  localparam int CW = $clog2(MB + 1);

  logic [PW-1:0] m1_r, m2_r, acc_r;
  logic [MB-1:0] b1_r, b2_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  // a1*b1 + a2*b2, one coefficient bit of each per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      m1_r  <= PW'(a1);
      m2_r  <= PW'(a2);
      b1_r  <= b1;
      b2_r  <= b2;
      acc_r <= '0;
    end else if (busy_r) begin
      m1_r  <= m1_r << 1;
      m2_r  <= m2_r << 1;
      b1_r  <= b1_r >> 1;
      b2_r  <= b2_r >> 1;
      acc_r <= acc_r + (b1_r[0] ? m1_r : '0) + (b2_r[0] ? m2_r : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(MB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign acc       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
